// File: src/assert_macros.svh
// assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define DEC_ASSERT_CR(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define DEC_ASSERT(name, prop, msg) \
  `DEC_ASSERT_CR(name, clk_i, rst_ni, prop, msg)

`else

`define DEC_ASSERT_CR(name, clk, rst_n, prop, msg)

`define DEC_ASSERT(name, prop, msg)

`endif

`endif

// File: src/dec_pkg.sv
package dec_pkg;

  localparam int unsigned COUNT_W   = 7;
  localparam int unsigned COUNT_MAX = 127;

  typedef struct packed {
    logic load;
    logic outer_clr;
    logic rd_outer;
    logic latch_cur;
    logic scan_clr;
    logic scan_step;
    logic commit;
    logic emit;
  } dec_cmd_t;

  typedef struct packed {
    logic i_last;
    logic scan_done;
    logic slot_free;
  } dec_sts_t;

endpackage

// File: src/dec_controller.sv
module dec_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              last_i,
  output logic              in_ready_o,
  input  dec_pkg::dec_sts_t sts_i,
  output dec_pkg::dec_cmd_t cmd_o
);
  import dec_pkg::*;

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_FETCH = 6'b000010,
    S_LATCH = 6'b000100,
    S_SCAN  = 6'b001000,
    S_NEXT  = 6'b010000,
    S_EMIT  = 6'b100000
  } dec_state_e;

  dec_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
        if (in_valid_i && last_i) begin
          cmd_o.outer_clr = 1'b1;
          state_d         = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.rd_outer = 1'b1;
        state_d        = S_LATCH;
      end
      S_LATCH: begin
        cmd_o.latch_cur = 1'b1;
        cmd_o.scan_clr  = 1'b1;
        state_d         = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        cmd_o.commit = 1'b1;
        state_d      = sts_i.i_last ? S_EMIT : S_FETCH;
      end
      S_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: src/dec_datapath.sv
`include "assert_macros.svh"

module dec_datapath #(
  parameter int unsigned MAX_ELEMENTS = 64,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [VALUE_WIDTH-1:0]     value_i,
  input  dec_pkg::dec_cmd_t                 cmd_i,
  output dec_pkg::dec_sts_t                 sts_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dec_pkg::COUNT_W-1:0]       duplicate_count_o,
  output logic                              overflow_o
);
  import dec_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned TW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [VALUE_WIDTH-1:0] mem [MAX_ELEMENTS];
  logic [VALUE_WIDTH-1:0] rd_data_q;
  logic [VALUE_WIDTH-1:0] cur_q;
  logic [AW-1:0]          rd_addr;

  logic [CW-1:0] fill_q, fill_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] j_q, j_d;
  logic [CW-1:0] cmp_idx_q, cmp_idx_d;
  logic          cmp_valid_q, cmp_valid_d;
  logic          hit_q, hit_d;
  logic [CW-1:0] total_q, total_d;
  logic          out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] dup_q;
  logic          out_ovf_q;

  logic          full;
  logic          wr_en;
  logic          match;
  logic [CW-1:0] i_nxt;
  logic [TW-1:0] total_ext;
  logic [COUNT_W-1:0] count_sat;

  assign full      = (fill_q == CW'(MAX_ELEMENTS));
  assign wr_en     = cmd_i.load && !full;
  assign rd_addr   = cmd_i.rd_outer ? i_q[AW-1:0] : j_q[AW-1:0];
  assign match     = cmp_valid_q && (cmp_idx_q != i_q) && (rd_data_q == cur_q);
  assign i_nxt     = i_q + CW'(1);
  assign total_ext = TW'(total_q);
  assign count_sat = (total_ext > TW'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                  : total_ext[COUNT_W-1:0];

  assign sts_o.i_last    = (i_nxt == fill_q);
  assign sts_o.scan_done = (j_q == fill_q) && !cmp_valid_q;
  assign sts_o.slot_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[fill_q[AW-1:0]] <= value_i;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_comb begin
    fill_d      = fill_q;
    ovf_d       = ovf_q;
    i_d         = i_q;
    j_d         = j_q;
    cmp_idx_d   = cmp_idx_q;
    cmp_valid_d = cmp_valid_q;
    hit_d       = hit_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        fill_d = fill_q + CW'(1);
      end
    end
    if (cmd_i.outer_clr) begin
      i_d     = '0;
      total_d = '0;
    end
    if (cmd_i.scan_clr) begin
      j_d         = '0;
      cmp_valid_d = 1'b0;
      hit_d       = 1'b0;
    end
    if (cmd_i.scan_step) begin
      if (match) begin
        hit_d = 1'b1;
      end
      if (j_q != fill_q) begin
        cmp_valid_d = 1'b1;
        cmp_idx_d   = j_q;
        j_d         = j_q + CW'(1);
      end else begin
        cmp_valid_d = 1'b0;
      end
    end
    if (cmd_i.commit) begin
      total_d = total_q + CW'(hit_q);
      i_d     = i_nxt;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      fill_d      = '0;
      ovf_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      cmp_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      i_q         <= i_d;
      j_q         <= j_d;
      cmp_valid_q <= cmp_valid_d;
      hit_q       <= hit_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= cmp_idx_d;
    if (cmd_i.latch_cur) begin
      cur_q <= rd_data_q;
    end
    if (cmd_i.emit) begin
      dup_q     <= count_sat;
      out_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign duplicate_count_o = dup_q;
  assign overflow_o        = out_ovf_q;

  `DEC_ASSERT(a_fill_bound, fill_q <= CW'(MAX_ELEMENTS), "fill count beyond capacity")
  `DEC_ASSERT(a_ovf_when_full, $rose(ovf_q) |-> $past(fill_q) == CW'(MAX_ELEMENTS), "drop while not full")
  `DEC_ASSERT(a_commit_in_range, cmd_i.commit |-> (i_q < fill_q) && (total_q <= i_q), "outer index or total out of range")
  `DEC_ASSERT(a_emit_slot_free, cmd_i.emit |-> sts_o.slot_free, "result written over pending result")

endmodule

// File: src/duplicate_element_counter_core.sv
// Duplicate element counter. Elements arrive one per transaction on the
// input channel, one per cycle, and are written to an element memory in
// arrival order; the transaction with last_i set closes the set. Up to
// MAX_ELEMENTS are kept, later ones are dropped and overflow_o is set in the
// result. After the closing transaction the block stops taking input and
// checks every stored element against all others through the single read
// port of the element memory, one compare per cycle. The pass is held at
// its end while the previous result has not been taken yet. One result
// transaction follows with the number of elements whose value occurs more
// than once (saturating at 127). The result sits in an output register, so
// the next set may load while it waits to be taken.
module duplicate_element_counter_core #(
  parameter int unsigned MAX_ELEMENTS = 64,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [dec_pkg::COUNT_W-1:0]   duplicate_count_o,
  output logic                          overflow_o
);
  import dec_pkg::*;

  dec_cmd_t cmd;
  dec_sts_t sts;

  dec_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .last_i     (last_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dec_datapath #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .value_i           (value_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .duplicate_count_o (duplicate_count_o),
    .overflow_o        (overflow_o)
  );

endmodule

// File: tb/dec_checker.sv
`timescale 1ns / 100ps

module dec_checker #(
  parameter int unsigned MAX_ELEMENTS = 64,
  parameter int unsigned VALUE_WIDTH  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic                          last_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [dec_pkg::COUNT_W-1:0]   duplicate_count_i,
  input  logic                          overflow_i,
  output int unsigned                   mismatches_o,
  output int unsigned                   pending_o
);

  typedef struct packed {
    logic [dec_pkg::COUNT_W-1:0] count;
    logic                        overflow;
  } dup_tally_t;

  logic signed [VALUE_WIDTH-1:0] sorted_store [MAX_ELEMENTS];
  int                            fill = 0;
  logic                          dropped = 1'b0;
  dup_tally_t                    tally_q [$];
  int unsigned                   mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic insert_element(input logic signed [VALUE_WIDTH-1:0] v);
    int pos;
    pos = fill;
    while (pos > 0 && sorted_store[pos-1] > v) begin
      sorted_store[pos] = sorted_store[pos-1];
      pos--;
    end
    sorted_store[pos] = v;
    fill++;
  endtask

  function automatic logic [dec_pkg::COUNT_W-1:0] count_duplicates();
    int  total;
    logic dup;
    total = 0;
    for (int i = 0; i < fill; i++) begin
      dup = 1'b0;
      if (i > 0 && sorted_store[i-1] == sorted_store[i]) dup = 1'b1;
      if (i + 1 < fill && sorted_store[i+1] == sorted_store[i]) dup = 1'b1;
      if (dup) total++;
    end
    if (total > dec_pkg::COUNT_MAX) total = dec_pkg::COUNT_MAX;
    return total[dec_pkg::COUNT_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dup_tally_t tally;
    if (!rst_ni) begin
      fill = 0;
      dropped = 1'b0;
      tally_q.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (tally_q.size() == 0) begin
          report_mismatch("result with none pending, count", duplicate_count_i, 0);
        end else begin
          tally = tally_q.pop_front();
          if (duplicate_count_i !== tally.count)
            report_mismatch("duplicate_count", duplicate_count_i, tally.count);
          if (overflow_i !== tally.overflow)
            report_mismatch("overflow", overflow_i, tally.overflow);
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (fill < MAX_ELEMENTS) insert_element(value_i);
        else dropped = 1'b1;
        if (last_i) begin
          tally.count = count_duplicates();
          tally.overflow = dropped;
          tally_q.push_back(tally);
          fill = 0;
          dropped = 1'b0;
        end
      end
      pending_o <= tally_q.size();
    end
  end

endmodule

// File: tb/tb_duplicate_element_counter_core.sv
`timescale 1ns / 100ps

module tb_duplicate_element_counter_core;

  localparam int unsigned MAX_ELEMENTS   = 64;
  localparam int unsigned VALUE_WIDTH    = 32;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES    = 600;

  localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic signed [VALUE_WIDTH-1:0] value_i;
  logic                          last_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [dec_pkg::COUNT_W-1:0]   duplicate_count_o;
  logic                          overflow_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_go = 1'b0;
  logic        receiver_hold = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned elements_sent = 0;
  int unsigned sets_sent = 0;
  int unsigned overfull_sets = 0;

  duplicate_element_counter_core #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .value_i          (value_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .duplicate_count_o(duplicate_count_o),
    .overflow_o       (overflow_o)
  );

  dec_checker #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .value_i          (value_i),
    .last_i           (last_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .duplicate_count_i(duplicate_count_o),
    .overflow_i       (overflow_o),
    .mismatches_o     (mismatches),
    .pending_o        (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver side
  always @(posedge clk_i) begin
    out_ready_i <= !receiver_hold && ($urandom_range(99) >= stall_pct);
  end

  // long receiver hold-off
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    receiver_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    receiver_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_element(input logic signed [VALUE_WIDTH-1:0] v, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    last_i     <= l;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    elements_sent++;
    if (l) sets_sent++;
  endtask

  function automatic logic signed [VALUE_WIDTH-1:0] draw_value();
    int unsigned sel;
    sel = $urandom_range(7);
    case (sel)
      0: begin
        return VAL_MIN;
      end
      1: begin
        return VAL_MAX;
      end
      2: begin
        return $signed(VALUE_WIDTH'($urandom_range(8))) - 4;
      end
      default: begin
        return VALUE_WIDTH'($urandom);
      end
    endcase
  endfunction

  task automatic send_random_set(input int unsigned size);
    logic signed [VALUE_WIDTH-1:0] pool [4];
    int unsigned                   pool_len;
    logic signed [VALUE_WIDTH-1:0] v;
    pool_len = $urandom_range(4, 1);
    for (int k = 0; k < 4; k++) pool[k] = draw_value();
    for (int unsigned n = 0; n < size; n++) begin
      if ($urandom_range(1)) v = pool[$urandom_range(pool_len - 1)];
      else v = draw_value();
      send_element(v, n == size - 1);
    end
    if (size > MAX_ELEMENTS) overfull_sets++;
  endtask

  task automatic send_small_sets(input int unsigned count, input int unsigned max_size);
    int unsigned target;
    int unsigned size;
    target = elements_sent + count;
    while (elements_sent < target) begin
      if ($urandom_range(9) == 0) size = $urandom_range(2 * max_size, 1);
      else size = $urandom_range(max_size, 1);
      send_random_set(size);
    end
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    value_i     = '0;
    last_i      = 1'b0;
    out_ready_i = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // extremes, single element, all equal, descending pair
    send_element(VAL_MIN, 1'b0);
    send_element(VAL_MAX, 1'b1);
    send_element('0, 1'b1);
    send_element(VAL_MAX, 1'b0);
    send_element(VAL_MIN, 1'b0);
    send_element(VAL_MAX, 1'b0);
    send_element(VAL_MIN, 1'b1);
    send_element(-1, 1'b0);
    send_element(0, 1'b0);
    send_element(-1, 1'b0);
    send_element(1, 1'b0);
    send_element(0, 1'b0);
    send_element(-1, 1'b1);
    send_element(5, 1'b0);
    send_element(5, 1'b0);
    send_element(5, 1'b1);
    send_element(32'h5555_5555, 1'b0);
    send_element(32'hAAAA_AAAA, 1'b0);
    send_element(32'h5555_5555, 1'b1);
    send_element(7, 1'b0);
    send_element(3, 1'b1);
    wait_for_results();

    // no idling, exactly full store
    send_small_sets(80, 10);
    send_random_set(MAX_ELEMENTS);
    wait_for_results();

    // sender idle, last element dropped past capacity
    idle_pct = 61;
    send_small_sets(80, 10);
    send_random_set(MAX_ELEMENTS + 1);
    wait_for_results();

    idle_pct = 0;
    stall_pct <= 61;
    send_small_sets(80, 10);
    wait_for_results();

    idle_pct = 14;
    stall_pct <= 14;
    send_small_sets(80, 10);
    send_random_set(MAX_ELEMENTS + 6);
    wait_for_results();

    // receiver holds off while the sender keeps going
    idle_pct = 0;
    stall_pct <= 0;
    hold_go <= 1'b1;
    send_small_sets(40, 4);
    wait_for_results();

    repeat (20) @(posedge clk_i);
    $display("covered %0d elements in %0d sets, %0d over capacity", elements_sent,
             sets_sent, overfull_sets);
    $display("handshake mixes: free flow, idle sender, stalling receiver, both, long hold-off");
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/dec_pkg.sv
src/dec_controller.sv
src/dec_datapath.sv
src/duplicate_element_counter_core.sv
tb/dec_checker.sv
tb/tb_duplicate_element_counter_core.sv
